// File: hw/rtl/mstsched_pkg.sv
// ----------------------------------------------------------------------------
// mstsched_pkg
// Types and codes shared by the timer scheduler controller and datapath.
// ----------------------------------------------------------------------------
package mstsched_pkg;

    localparam int TIME_BITS = 24;
    localparam int ID_BITS   = 8;

    localparam logic [2:0] MODE_SCHED   = 3'd0;
    localparam logic [2:0] MODE_UNSCHED = 3'd1;
    localparam logic [2:0] MODE_UNALL   = 3'd2;
    localparam logic [2:0] MODE_PAUSE   = 3'd3;
    localparam logic [2:0] MODE_RESUME  = 3'd4;
    localparam logic [2:0] MODE_QUERY   = 3'd5;
    localparam logic [2:0] MODE_TICK    = 3'd6;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIRE,
        S_APPLY,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the command, clear scan results
        logic start;    // not read by the datapath; load resets the slot index
        logic step;     // evaluate and commit the current slot, advance
        logic apply;    // commit the scan result of a command
        logic fire_out; // present a fired result
        logic fin_out;  // present the final result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_slot;
        logic fire;     // current slot fires this step
        logic is_tick;
    } t_stat;

endpackage

// File: hw/rtl/multi_slot_timer_scheduler_top.sv
// ----------------------------------------------------------------------------
// multi_slot_timer_scheduler_top
// Timer slot table with schedule, unschedule, pause, resume, query and tick.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser: mode, tdata: command fields
// m_axis   out  m_axis_tvalid/m_axis_tready  tuser: kind, tdata + tlast: results
//
// An item passes through a load step, a scan step for each slot and a
// response; a command also commits its scan result before the response.
// Each firing result waits until the output register is free.
// Reset clears the valid bits, the output valid flag and the sequencer.
// Output stalls hold a tick scan at a firing slot, and hold the response.
module multi_slot_timer_scheduler_top
    import mstsched_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[2:0]
    input  logic [2:0]   s_axis_tuser,
    // target_id[7:0] selector_id[15:8] interval[39:16] repeats[55:40]
    // forever_req[56] delay[80:57] start_paused[81] dt[105:82]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    // status[2:0] out_target[10:3] out_selector[18:11] is_paused[19]
    output logic [23:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_busy;

    mstsched_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_busy  (w_busy),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    mstsched_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_mode         (s_axis_tuser),
        .i_target_id    (s_axis_tdata[7:0]),
        .i_selector_id  (s_axis_tdata[15:8]),
        .i_interval     (s_axis_tdata[39:16]),
        .i_repeats      (s_axis_tdata[55:40]),
        .i_forever_req  (s_axis_tdata[56]),
        .i_delay        (s_axis_tdata[80:57]),
        .i_start_paused (s_axis_tdata[81]),
        .i_dt           (s_axis_tdata[105:82]),
        .i_out_ready    (m_axis_tready),
        .o_stat         (w_stat),
        .o_out_busy     (w_busy),
        .o_out_valid    (m_axis_tvalid),
        .o_out_kind     (m_axis_tuser),
        .o_out_data     (m_axis_tdata),
        .o_out_last     (m_axis_tlast)
    );

endmodule

// File: hw/rtl/mstsched_ctrl.sv
// ----------------------------------------------------------------------------
// mstsched_ctrl
// Sequencer: one scan pass over the slots per item, holding on output stalls.
// ----------------------------------------------------------------------------
module mstsched_ctrl
    import mstsched_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_busy,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                // a firing slot waits for the output register
                if (i_stat.is_tick && i_stat.fire) begin
                    if (!i_out_busy) n_state = i_stat.last_slot ? S_RESP : S_SCAN;
                end else if (i_stat.last_slot) begin
                    n_state = i_stat.is_tick ? S_RESP : S_APPLY;
                end
            end
            S_APPLY: n_state = S_RESP;
            S_RESP: begin
                if (!i_out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                if (i_stat.is_tick && i_stat.fire) begin
                    o_cmd.step     = !i_out_busy;
                    o_cmd.fire_out = !i_out_busy;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_APPLY: o_cmd.apply = 1'b1;
            S_RESP:  o_cmd.fin_out = !i_out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (!(r_state == S_IDLE && o_cmd.step))
                else $error("slot step while idle");
            assert (!(o_cmd.fire_out && o_cmd.fin_out))
                else $error("two results in one cycle");
            assert (!(o_cmd.apply && !(r_state == S_APPLY)))
                else $error("apply outside its state");
        end
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_scan_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_SCAN) else $error("no scan after load");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin_out |=> r_state == S_IDLE) else $error("no return to idle");

endmodule

// File: hw/rtl/mstsched_dp.sv
// ----------------------------------------------------------------------------
// mstsched_dp
// Slot table, per-slot update unit, scan bookkeeping and output register.
// ----------------------------------------------------------------------------
module mstsched_dp
    import mstsched_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_target_id,
    input  logic [7:0]  i_selector_id,
    input  logic [23:0] i_interval,
    input  logic [15:0] i_repeats,
    input  logic        i_forever_req,
    input  logic [23:0] i_delay,
    input  logic        i_start_paused,
    input  logic [23:0] i_dt,
    input  logic        i_out_ready,
    output t_stat       o_stat,
    output logic        o_out_busy,
    output logic        o_out_valid,
    output logic [1:0]  o_out_kind,
    output logic [23:0] o_out_data,
    output logic        o_out_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic                 r_valid [SLOTS];
    logic [ID_BITS-1:0]   r_tgt   [SLOTS];
    logic [ID_BITS-1:0]   r_sel   [SLOTS];
    logic [TIME_BITS-1:0] r_ivl   [SLOTS];
    logic [TIME_BITS-1:0] r_dly   [SLOTS];
    logic [15:0]          r_rep   [SLOTS];
    logic                 r_fev   [SLOTS];
    logic                 r_udl   [SLOTS];
    logic                 r_arm   [SLOTS];
    logic                 r_pau   [SLOTS];
    logic [TIME_BITS-1:0] r_ela   [SLOTS];
    logic [15:0]          r_cnt   [SLOTS];

    logic [2:0]           r_mode;
    logic [ID_BITS-1:0]   r_ctgt, r_csel;
    logic [TIME_BITS-1:0] r_civl, r_cdly, r_cdt;
    logic [15:0]          r_crep;
    logic                 r_cfev, r_cspa;
    logic [IW-1:0]        r_idx;
    logic                 r_pair_hit, r_tgt_hit, r_free_hit, r_tpau;
    logic [IW-1:0]        r_pair_idx, r_free_idx;

    logic                 r_ov;
    logic [1:0]           r_okind;
    logic [2:0]           r_ostat;
    logic [7:0]           r_otgt, r_osel;
    logic                 r_opau, r_olast;

    // current slot
    logic                 c_act, c_tm, c_pm;
    logic [TIME_BITS:0]   c_sum;
    logic [TIME_BITS-1:0] c_e, c_ne;
    logic                 c_fire, c_nudl, c_free;
    logic [15:0]          c_ncnt;

    always_comb begin
        c_tm   = r_valid[r_idx] && (r_tgt[r_idx] == r_ctgt);
        c_pm   = c_tm && (r_sel[r_idx] == r_csel);
        c_act  = r_valid[r_idx] && !r_pau[r_idx] && r_arm[r_idx];
        c_sum  = {1'b0, r_ela[r_idx]} + {1'b0, r_cdt};
        c_e    = c_sum[TIME_BITS] ? TMAX : c_sum[TIME_BITS-1:0];
        c_fire = 1'b0;
        c_ne   = c_e;
        c_nudl = r_udl[r_idx];
        if (r_udl[r_idx]) begin
            if (c_e >= r_dly[r_idx]) begin
                c_fire = 1'b1;
                c_ne   = c_e - r_dly[r_idx];
                c_nudl = 1'b0;
            end
        end else if (c_e >= r_ivl[r_idx]) begin
            c_fire = 1'b1;
            c_ne   = '0;
        end
        c_fire = c_fire && c_act;
        c_ncnt = (c_fire && r_cnt[r_idx] != 16'hFFFF) ? r_cnt[r_idx] + 16'd1
                                                     : r_cnt[r_idx];
        c_free = !r_fev[r_idx] && (c_ncnt >= r_rep[r_idx]);
    end

    assign o_stat.last_slot = (r_idx == IW'(SLOTS - 1));
    assign o_stat.fire      = c_fire;
    assign o_stat.is_tick   = (r_mode == MODE_TICK);
    assign o_out_busy       = r_ov && !i_out_ready;

    // command bookkeeping and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_ctgt <= i_target_id[ID_BITS-1:0];
            r_csel <= i_selector_id[ID_BITS-1:0];
            r_civl <= i_interval[TIME_BITS-1:0];
            r_cdly <= i_delay[TIME_BITS-1:0];
            r_cdt  <= i_dt[TIME_BITS-1:0];
            r_crep <= i_repeats;
            r_cfev <= i_forever_req;
            r_cspa <= i_start_paused;
            r_idx  <= '0;
            r_pair_hit <= 1'b0;
            r_tgt_hit  <= 1'b0;
            r_free_hit <= 1'b0;
            r_tpau     <= 1'b0;
            r_pair_idx <= '0;
            r_free_idx <= '0;
        end else if (i_cmd.step) begin
            if (!o_stat.last_slot) r_idx <= r_idx + IW'(1);
            if (c_pm && !r_pair_hit) begin
                r_pair_hit <= 1'b1;
                r_pair_idx <= r_idx;
            end
            if (c_tm && !r_tgt_hit) begin
                r_tgt_hit <= 1'b1;
                r_tpau    <= r_pau[r_idx];
            end
            if (!r_valid[r_idx] && !r_free_hit) begin
                r_free_hit <= 1'b1;
                r_free_idx <= r_idx;
            end
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) r_valid[k] <= 1'b0;
        end else if (i_cmd.step) begin
            unique case (r_mode)
                MODE_TICK: begin
                    if (r_valid[r_idx] && !r_pau[r_idx]) begin
                        if (!r_arm[r_idx]) begin
                            r_arm[r_idx] <= 1'b1;
                            r_ela[r_idx] <= '0;
                            r_cnt[r_idx] <= '0;
                        end else begin
                            r_ela[r_idx] <= c_ne;
                            r_udl[r_idx] <= c_nudl;
                            r_cnt[r_idx] <= c_ncnt;
                            if (c_free) r_valid[r_idx] <= 1'b0;
                        end
                    end
                end
                MODE_UNALL:  if (c_tm) r_valid[r_idx] <= 1'b0;
                MODE_PAUSE:  if (c_tm) r_pau[r_idx] <= 1'b1;
                MODE_RESUME: if (c_tm) r_pau[r_idx] <= 1'b0;
                default: ;
            endcase
        end else if (i_cmd.apply) begin
            if (r_mode == MODE_SCHED) begin
                if (r_pair_hit) begin
                    r_ivl[r_pair_idx] <= r_civl;
                end else if (r_free_hit) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_pau[r_free_idx]   <= r_tgt_hit ? r_tpau : r_cspa;
                    r_tgt[r_free_idx]   <= r_ctgt;
                    r_sel[r_free_idx]   <= r_csel;
                    r_ivl[r_free_idx]   <= r_civl;
                    r_dly[r_free_idx]   <= r_cdly;
                    r_rep[r_free_idx]   <= r_crep;
                    r_fev[r_free_idx]   <= r_cfev;
                    r_udl[r_free_idx]   <= (r_cdly != '0);
                    r_arm[r_free_idx]   <= 1'b0;
                    r_ela[r_free_idx]   <= '0;
                    r_cnt[r_free_idx]   <= '0;
                end
            end else if (r_mode == MODE_UNSCHED && r_pair_hit) begin
                r_valid[r_pair_idx] <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.fire_out || i_cmd.fin_out) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire_out) begin
            r_okind <= KIND_FIRED;
            r_ostat <= ST_DONE;
            r_otgt  <= 8'(r_tgt[r_idx]);
            r_osel  <= 8'(r_sel[r_idx]);
            r_opau  <= 1'b0;
            r_olast <= 1'b0;
        end else if (i_cmd.fin_out) begin
            r_otgt  <= '0;
            r_osel  <= '0;
            r_opau  <= 1'b0;
            r_olast <= 1'b1;
            r_okind <= (r_mode == MODE_TICK) ? KIND_TICK : KIND_STATUS;
            unique case (r_mode)
                MODE_TICK: r_ostat <= ST_DONE;
                MODE_SCHED: r_ostat <= r_pair_hit ? ST_UPDATED :
                                       (r_free_hit ? ST_INSERTED : ST_FULL);
                MODE_UNSCHED: r_ostat <= r_pair_hit ? ST_DONE : ST_NOTFOUND;
                MODE_UNALL, MODE_PAUSE, MODE_RESUME:
                    r_ostat <= r_tgt_hit ? ST_DONE : ST_NOTFOUND;
                MODE_QUERY: begin
                    r_ostat <= r_tgt_hit ? ST_DONE : ST_NOTFOUND;
                    r_opau  <= r_tgt_hit && r_tpau;
                end
                default: r_ostat <= ST_NOTFOUND;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_last  = r_olast;
    assign o_out_kind  = r_okind;
    assign o_out_data  = {4'b0000, r_opau, r_osel, r_otgt, r_ostat};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |-> !(i_cmd.fire_out || i_cmd.fin_out))
        else $error("output overwritten while stalled");
    a_fire_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire_out |-> (r_valid[r_idx] && r_arm[r_idx] && !r_pau[r_idx]))
        else $error("fire from inactive slot");
    a_idx_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_idx == '0) else $error("scan index not cleared");

endmodule

// File: tb/sv/multi_slot_timer_scheduler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_slot_timer_scheduler_top_tb
// Drives schedule, unschedule, pause, resume, query and tick transactions into
// the timer table and checks every result against a slot-table model.
// ----------------------------------------------------------------------------
module multi_slot_timer_scheduler_top_tb
    import mstsched_pkg::*;
();

    localparam int NSLOT = 16;
    localparam logic [23:0] TMAX = 24'hFFFFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  tgt;
        logic [7:0]  sel;
        logic [23:0] interval;
        logic [15:0] repeats;
        logic        forever_req;
        logic [23:0] delay;
        logic        start_paused;
        logic [23:0] dt;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] status;
        logic [7:0] tgt;
        logic [7:0] sel;
        logic       paused;
        logic       last;
    } t_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [2:0]   s_axis_tuser;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [1:0]   m_axis_tuser;
    logic [23:0]  m_axis_tdata;
    logic         m_axis_tlast;

    multi_slot_timer_scheduler_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // slot table copy
    logic        tv_valid    [NSLOT];
    logic [7:0]  tv_tgt      [NSLOT];
    logic [7:0]  tv_sel      [NSLOT];
    logic [23:0] tv_interval [NSLOT];
    logic [23:0] tv_delay    [NSLOT];
    logic [15:0] tv_repeats  [NSLOT];
    logic        tv_forever  [NSLOT];
    logic        tv_use_delay[NSLOT];
    logic        tv_armed    [NSLOT];
    logic        tv_paused   [NSLOT];
    logic [23:0] tv_elapsed  [NSLOT];
    logic [15:0] tv_count    [NSLOT];

    t_res pending_results[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_off = 0;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    initial begin
        #4000000;
        $display("multi_slot_timer_scheduler_top_tb NOT OK");
        $finish;
    end

    function automatic t_res mk_res(logic [1:0] k, logic [2:0] s, logic [7:0] t,
                                    logic [7:0] sl, logic p);
        t_res r;
        r.kind = k; r.status = s; r.tgt = t; r.sel = sl; r.paused = p; r.last = 0;
        return r;
    endfunction

    // advance the slot table by one transaction, push the expected results
    task automatic predict_timer_results(input t_req q);
        int   p, t, fr;
        bit   any, fire;
        logic [24:0] e;
        t_res outs[$];
        p = -1; t = -1; fr = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (tv_valid[i] && tv_tgt[i] == q.tgt && t < 0) t = i;
            if (tv_valid[i] && tv_tgt[i] == q.tgt && tv_sel[i] == q.sel && p < 0) p = i;
            if (!tv_valid[i] && fr < 0) fr = i;
        end
        case (q.mode)
            MODE_SCHED: begin
                if (p >= 0) begin
                    tv_interval[p] = q.interval;
                    outs.push_back(mk_res(KIND_STATUS, ST_UPDATED, 0, 0, 0));
                end else if (fr < 0) begin
                    outs.push_back(mk_res(KIND_STATUS, ST_FULL, 0, 0, 0));
                end else begin
                    tv_paused[fr]    = (t >= 0) ? tv_paused[t] : q.start_paused;
                    tv_valid[fr]     = 1;
                    tv_tgt[fr]       = q.tgt;
                    tv_sel[fr]       = q.sel;
                    tv_interval[fr]  = q.interval;
                    tv_delay[fr]     = q.delay;
                    tv_repeats[fr]   = q.repeats;
                    tv_forever[fr]   = q.forever_req;
                    tv_use_delay[fr] = q.delay != 0;
                    tv_armed[fr]     = 0;
                    tv_elapsed[fr]   = 0;
                    tv_count[fr]     = 0;
                    outs.push_back(mk_res(KIND_STATUS, ST_INSERTED, 0, 0, 0));
                end
            end
            MODE_UNSCHED: begin
                if (p >= 0) tv_valid[p] = 0;
                outs.push_back(mk_res(KIND_STATUS, p >= 0 ? ST_DONE : ST_NOTFOUND,
                                      0, 0, 0));
            end
            MODE_UNALL, MODE_PAUSE, MODE_RESUME: begin
                any = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (tv_valid[i] && tv_tgt[i] == q.tgt) begin
                        any = 1;
                        if (q.mode == MODE_UNALL) tv_valid[i] = 0;
                        else tv_paused[i] = (q.mode == MODE_PAUSE);
                    end
                end
                outs.push_back(mk_res(KIND_STATUS, any ? ST_DONE : ST_NOTFOUND, 0, 0, 0));
            end
            MODE_QUERY: begin
                if (t >= 0) outs.push_back(mk_res(KIND_STATUS, ST_DONE, 0, 0, tv_paused[t]));
                else outs.push_back(mk_res(KIND_STATUS, ST_NOTFOUND, 0, 0, 0));
            end
            MODE_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!tv_valid[i] || tv_paused[i]) continue;
                    if (!tv_armed[i]) begin
                        tv_armed[i] = 1; tv_elapsed[i] = 0; tv_count[i] = 0;
                        continue;
                    end
                    fire = 0;
                    e = {1'b0, tv_elapsed[i]} + {1'b0, q.dt};
                    if (e > {1'b0, TMAX}) e = {1'b0, TMAX};
                    if (tv_use_delay[i]) begin
                        if (e >= {1'b0, tv_delay[i]}) begin
                            fire = 1; e = e - {1'b0, tv_delay[i]}; tv_use_delay[i] = 0;
                        end
                    end else if (e >= {1'b0, tv_interval[i]}) begin
                        fire = 1; e = 0;
                    end
                    tv_elapsed[i] = e[23:0];
                    if (fire) begin
                        if (tv_count[i] != 16'hFFFF) tv_count[i]++;
                        outs.push_back(mk_res(KIND_FIRED, ST_DONE, tv_tgt[i], tv_sel[i], 0));
                    end
                    if (!tv_forever[i] && tv_count[i] >= tv_repeats[i]) tv_valid[i] = 0;
                end
                outs.push_back(mk_res(KIND_TICK, ST_DONE, 0, 0, 0));
            end
            default: outs.push_back(mk_res(KIND_STATUS, ST_NOTFOUND, 0, 0, 0));
        endcase
        outs[outs.size()-1].last = 1;
        foreach (outs[k]) pending_results.push_back(outs[k]);
    endtask

    function automatic t_req mk_req(logic [2:0] m, logic [7:0] t, logic [7:0] s,
                                    logic [23:0] iv, logic [15:0] rp, logic fv,
                                    logic [23:0] dl, logic sp, logic [23:0] d);
        t_req q;
        q.mode = m; q.tgt = t; q.sel = s; q.interval = iv; q.repeats = rp;
        q.forever_req = fv; q.delay = dl; q.start_paused = sp; q.dt = d;
        return q;
    endfunction

    // hand one transaction over, updating the model as it is accepted
    task automatic send_cmd(input t_req q);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= q.mode;
        s_axis_tdata  <= {6'b0, q.dt, q.start_paused, q.delay, q.forever_req,
                          q.repeats, q.interval, q.sel, q.tgt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_timer_results(q);
    endtask

    // receiver: random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !hold_off && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3],
                   m_axis_tdata[18:11], m_axis_tdata[19], m_axis_tlast};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    t_req directed[$];

    task automatic random_cmd(input int tgt_span);
        t_req         q;
        int           pick;
        logic [127:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom};
        q = rnd[$bits(t_req)-1:0];
        q.tgt = (tgt_span > 0) ? 8'($urandom_range(tgt_span, 0)) : q.tgt;
        if (tgt_span > 0) q.sel = 8'($urandom_range(3, 0));
        pick = $urandom_range(99, 0);
        if (pick < 35) begin
            q.mode = MODE_SCHED;
            q.interval = ($urandom_range(3, 0) == 0) ? q.interval : 24'($urandom_range(40, 0));
            q.delay    = ($urandom_range(3, 0) == 0) ? q.delay : 24'($urandom_range(30, 0));
            q.repeats  = ($urandom_range(3, 0) == 0) ? q.repeats : 16'($urandom_range(4, 0));
        end else if (pick < 75) begin
            q.mode = MODE_TICK;
            q.dt = ($urandom_range(7, 0) == 0) ? q.dt : 24'($urandom_range(25, 0));
        end else begin
            q.mode = 3'($urandom_range(7, 1));
        end
        send_cmd(q);
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        for (int i = 0; i < NSLOT; i++) tv_valid[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-table answers, extremes, delay overshoot, zero repeats
        directed.push_back(mk_req(MODE_QUERY, 8'hFF, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_UNSCHED, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_UNALL, 1, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_PAUSE, 1, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_RESUME, 1, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(3'd7, 1, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, TMAX));
        directed.push_back(mk_req(MODE_SCHED, 1, 1, 5, 2, 0, 3, 0, 0));
        directed.push_back(mk_req(MODE_SCHED, 1, 1, 4, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_SCHED, 1, 2, 0, 0, 0, 0, 1, 0));
        directed.push_back(mk_req(MODE_SCHED, 2, 9, 0, 0, 0, 0, 1, 0));
        directed.push_back(mk_req(MODE_SCHED, 8'hFF, 8'hFF, TMAX, 16'hFFFF, 1, TMAX, 0, 0));
        directed.push_back(mk_req(MODE_QUERY, 2, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 7));
        directed.push_back(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, TMAX));
        directed.push_back(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, TMAX));
        directed.push_back(mk_req(MODE_RESUME, 2, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_UNSCHED, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(MODE_UNALL, 1, 0, 0, 0, 0, 0, 0, 0));
        foreach (directed[k]) send_cmd(directed[k]);
        // fill the table past full
        for (int k = 0; k < 18; k++)
            send_cmd(mk_req(MODE_SCHED, 8'(k), 8'(k), 3, 1, k[0], 0, k[1], 0));
        send_cmd(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0));

        // long hold-off while the sender keeps offering ticks
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < 6; k++) send_cmd(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 5));
        join

        send_idle_pct = 8; recv_idle_pct = 87;
        for (int k = 0; k < 70; k++) random_cmd(k < 60 ? 5 : 0);
        send_idle_pct = 87; recv_idle_pct = 8;
        for (int k = 0; k < 70; k++) random_cmd(k < 60 ? 5 : 0);
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int k = 0; k < 70; k++) random_cmd(k < 60 ? 5 : 0);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("multi_slot_timer_scheduler_top_tb OK");
        else $display("multi_slot_timer_scheduler_top_tb NOT OK");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/mstsched_pkg.sv
hw/rtl/mstsched_ctrl.sv
hw/rtl/mstsched_dp.sv
hw/rtl/multi_slot_timer_scheduler_top.sv
tb/sv/multi_slot_timer_scheduler_top_tb.sv
